// ===== sv/tre_pkg.sv =====
// ----------------------------------------------------------------------------
// TCP RTT estimator package
// Shared constants, register indexes and controller/datapath link types.
// ----------------------------------------------------------------------------
package tre_pkg;

	localparam int HISTORY_DEPTH_DEF = 16;
	localparam int CFG_IDX_W         = 1;

	localparam logic [31:0] RTT_LIMIT = 32'd10000000;
	localparam logic [31:0] PER_MILLE = 32'd1000;
	localparam logic [9:0]  WEIGHT_RESET = 10'd875;

	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRTT_RESTART_VALUE = 1'd1;

	typedef enum logic [1:0] {
		DIV_AVG  = 2'd0,
		DIV_VAR  = 2'd1,
		DIV_EWMA = 2'd2
	} tre_div_sel_t;

	typedef struct packed {
		logic         load_item;
		logic         write_sample;
		logic         sum_add;
		logic         sq_mul;
		logic         sq_acc;
		logic         idx_inc;
		logic         div_start;
		tre_div_sel_t div_sel;
		logic         cap_avg;
		logic         cap_var;
		logic         mul1;
		logic         mul2;
		logic         finish;
		logic         load_out;
	} tre_cmd_t;

	typedef struct packed {
		logic need_sample;
		logic idx_last;
		logic div_done;
		logic srtt_restart;
	} tre_status_t;

endpackage

// ===== sv/tre_item_if.sv =====
// ----------------------------------------------------------------------------
// Item channel
// Carries one record or echo item from source to sink.
// ----------------------------------------------------------------------------
interface tre_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] sent_tsval;
	logic [31:0] echo_tsecr;
	logic [31:0] now_us;
	logic        option_present;

	modport source (output valid, operation, sent_tsval, echo_tsecr, now_us, option_present,
		input ready);
	modport sink (input valid, operation, sent_tsval, echo_tsecr, now_us, option_present,
		output ready);
endinterface

// ===== sv/tre_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Carries one result beat with the RTT statistics.
// ----------------------------------------------------------------------------
interface tre_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] rtt_us;
	logic        sample_accepted;
	logic        timestamps_on;
	logic [31:0] smoothed_rtt;
	logic [23:0] lowest_rtt;
	logic [23:0] highest_rtt;
	logic [31:0] rtt_variance;
	logic [31:0] sample_total;

	modport source (output valid, rtt_us, sample_accepted, timestamps_on, smoothed_rtt,
		lowest_rtt, highest_rtt, rtt_variance, sample_total, input ready);
	modport sink (input valid, rtt_us, sample_accepted, timestamps_on, smoothed_rtt,
		lowest_rtt, highest_rtt, rtt_variance, sample_total, output ready);
endinterface

// ===== sv/tre_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tre_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tre_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/tre_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tre_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end
endmodule

// ===== sv/tre_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// 32-bit unsigned quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tre_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done_q,
	output logic [31:0] quo_q
);
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
endmodule

// ===== sv/tre_ctrl.sv =====
// ----------------------------------------------------------------------------
// RTT estimator controller
// Sequences the history walks, the divisions and the result hand-off.
// ----------------------------------------------------------------------------
module tre_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	output logic                 result_valid,
	input  logic                 result_ready,
	input  tre_pkg::tre_status_t status,
	output tre_pkg::tre_cmd_t    cmd
);
	import tre_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE     = 18'h00001,
		S_CHECK    = 18'h00002,
		S_WRITE    = 18'h00004,
		S_SUM_RD   = 18'h00008,
		S_SUM_ADD  = 18'h00010,
		S_AVG_GO   = 18'h00020,
		S_AVG_WAIT = 18'h00040,
		S_SQ_RD    = 18'h00080,
		S_SQ_MUL   = 18'h00100,
		S_SQ_ACC   = 18'h00200,
		S_VAR_GO   = 18'h00400,
		S_VAR_WAIT = 18'h00800,
		S_EW_MUL1  = 18'h01000,
		S_EW_MUL2  = 18'h02000,
		S_EW_GO    = 18'h04000,
		S_EW_WAIT  = 18'h08000,
		S_FINISH   = 18'h10000,
		S_OUT      = 18'h20000
	} tre_state_t;

	tre_state_t state_q, state_d;
	logic       out_valid_q;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_CHECK:   state_d = status.need_sample ? S_WRITE : S_OUT;
			S_WRITE: begin
				cmd.write_sample = 1'b1;
				state_d          = S_SUM_RD;
			end
			S_SUM_RD:  state_d = S_SUM_ADD;
			S_SUM_ADD: begin
				cmd.sum_add = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = status.idx_last ? S_AVG_GO : S_SUM_RD;
			end
			S_AVG_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_AVG;
				state_d       = S_AVG_WAIT;
			end
			S_AVG_WAIT: begin
				if (status.div_done) begin
					cmd.cap_avg = 1'b1;
					state_d     = S_SQ_RD;
				end
			end
			S_SQ_RD:   state_d = S_SQ_MUL;
			S_SQ_MUL: begin
				cmd.sq_mul = 1'b1;
				state_d    = S_SQ_ACC;
			end
			S_SQ_ACC: begin
				cmd.sq_acc  = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = status.idx_last ? S_VAR_GO : S_SQ_RD;
			end
			S_VAR_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_VAR;
				state_d       = S_VAR_WAIT;
			end
			S_VAR_WAIT: begin
				if (status.div_done) begin
					cmd.cap_var = 1'b1;
					state_d     = status.srtt_restart ? S_FINISH : S_EW_MUL1;
				end
			end
			S_EW_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_EW_MUL2;
			end
			S_EW_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_EW_GO;
			end
			S_EW_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_EWMA;
				state_d       = S_EW_WAIT;
			end
			S_EW_WAIT: begin
				if (status.div_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || result_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== sv/tre_dp.sv =====
// ----------------------------------------------------------------------------
// RTT estimator datapath
// Flow state, sample history, statistics arithmetic and the result register.
// ----------------------------------------------------------------------------
module tre_dp #(
	parameter int HISTORY_DEPTH = tre_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tre_pkg::tre_cmd_t             cmd,
	output tre_pkg::tre_status_t          status,
	input  logic                          operation,
	input  logic [31:0]                   sent_tsval,
	input  logic [31:0]                   echo_tsecr,
	input  logic [31:0]                   now_us,
	input  logic                          option_present,
	input  logic                          cfg_we,
	input  logic [tre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output logic [31:0]                   rtt_us,
	output logic                          sample_accepted,
	output logic                          timestamps_on,
	output logic [31:0]                   smoothed_rtt,
	output logic [23:0]                   lowest_rtt,
	output logic [23:0]                   highest_rtt,
	output logic [31:0]                   rtt_variance,
	output logic [31:0]                   sample_total
);
	import tre_pkg::*;

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FW = $clog2(HISTORY_DEPTH + 1);
	localparam logic [AW-1:0] LAST_POS = AW'(HISTORY_DEPTH - 1);
	localparam logic [FW-1:0] FULL     = FW'(HISTORY_DEPTH);

	logic [9:0]  weight_q;
	logic [31:0] restart_q;
	logic [31:0] tsval_q, send_time_q;
	logic        ts_flag_q;
	logic [31:0] rtt_q;
	logic        smp_ok_q;
	logic [AW-1:0] pos_q, idx_q;
	logic [FW-1:0] fill_q;
	logic [23:0] min_q, max_q;
	logic [31:0] var_q, srtt_q, count_q;
	logic [31:0] sum_q, avg_q, sq_q, var_acc_q, p1_q, p2_q;

	logic [31:0] rtt_calc;
	logic        rtt_ok;
	logic [23:0] rdata;
	logic [31:0] dev;
	logic [31:0] sq_full, p1_full, p2_full;
	logic [31:0] div_dividend, div_divisor, quo;
	logic        div_done;
	logic [FW:0] idx_next;

	// Candidate RTT: exact TSval match uses the stored send time, otherwise TSecr is a time.
	always_comb begin
		rtt_calc = '0;
		if (echo_tsecr != '0 && tsval_q != '0) begin
			if (echo_tsecr == tsval_q) begin
				rtt_calc = now_us - send_time_q;
			end else if (echo_tsecr < now_us && (now_us - echo_tsecr) < RTT_LIMIT) begin
				rtt_calc = now_us - echo_tsecr;
			end
		end
	end
	assign rtt_ok = operation && option_present && rtt_calc != '0 && rtt_calc < RTT_LIMIT;

	assign dev     = {8'd0, rdata} - avg_q;
	assign sq_full = dev * dev;
	assign p1_full = srtt_q * {22'd0, weight_q};
	assign p2_full = rtt_q * (PER_MILLE - {22'd0, weight_q});

	always_comb begin
		unique case (cmd.div_sel)
			DIV_AVG: begin
				div_dividend = sum_q;
				div_divisor  = 32'(fill_q);
			end
			DIV_VAR: begin
				div_dividend = var_acc_q;
				div_divisor  = 32'(fill_q);
			end
			DIV_EWMA: begin
				div_dividend = p1_q + p2_q;
				div_divisor  = PER_MILLE;
			end
			default: begin
				div_dividend = '0;
				div_divisor  = 32'd1;
			end
		endcase
	end

	assign idx_next = (FW + 1)'(idx_q) + (FW + 1)'(1);

	assign status.need_sample  = smp_ok_q;
	assign status.idx_last     = (idx_next == {1'b0, fill_q});
	assign status.div_done     = div_done;
	assign status.srtt_restart = (srtt_q == '0) || (srtt_q == restart_q);

	tre_ram #(
		.WIDTH(24),
		.DEPTH(HISTORY_DEPTH)
	) u_ring (
		.clk    (clk),
		.we     (cmd.write_sample),
		.waddr  (pos_q),
		.wdata  (rtt_q[23:0]),
		.raddr  (idx_q),
		.rdata_q(rdata)
	);

	tre_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done_q  (div_done),
		.quo_q   (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q    <= WEIGHT_RESET;
			restart_q   <= '0;
			tsval_q     <= '0;
			send_time_q <= '0;
			ts_flag_q   <= 1'b0;
			smp_ok_q    <= 1'b0;
			pos_q       <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			min_q       <= '0;
			max_q       <= '0;
			var_q       <= '0;
			srtt_q      <= '0;
			count_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SMOOTHING_WEIGHT:   weight_q  <= cfg_data[9:0];
					REG_SRTT_RESTART_VALUE: restart_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load_item) begin
				smp_ok_q <= rtt_ok;
				if (!operation) begin
					tsval_q     <= sent_tsval;
					send_time_q <= now_us;
				end else begin
					ts_flag_q <= option_present;
				end
			end
			if (cmd.write_sample) begin
				pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + AW'(1);
				if (fill_q < FULL) begin
					fill_q <= fill_q + FW'(1);
				end
				if (rtt_q[23:0] < min_q || min_q == '0) begin
					min_q <= rtt_q[23:0];
				end
				if (rtt_q[23:0] > max_q) begin
					max_q <= rtt_q[23:0];
				end
				idx_q <= '0;
			end else if (cmd.cap_avg) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.cap_var) begin
				var_q <= quo;
			end
			if (cmd.finish) begin
				srtt_q  <= status.srtt_restart ? rtt_q : quo;
				count_q <= count_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			rtt_q <= (operation && option_present) ? rtt_calc : '0;
		end
		if (cmd.write_sample) begin
			sum_q <= '0;
		end else if (cmd.sum_add) begin
			sum_q <= sum_q + {8'd0, rdata};
		end
		if (cmd.cap_avg) begin
			avg_q     <= quo;
			var_acc_q <= '0;
		end else if (cmd.sq_acc) begin
			var_acc_q <= var_acc_q + sq_q;
		end
		if (cmd.sq_mul) begin
			sq_q <= sq_full[31:0];
		end
		if (cmd.mul1) begin
			p1_q <= p1_full[31:0];
		end
		if (cmd.mul2) begin
			p2_q <= p2_full[31:0];
		end
		if (cmd.load_out) begin
			rtt_us          <= rtt_q;
			sample_accepted <= smp_ok_q;
			timestamps_on   <= ts_flag_q;
			smoothed_rtt    <= srtt_q;
			lowest_rtt      <= min_q;
			highest_rtt     <= max_q;
			rtt_variance    <= var_q;
			sample_total    <= count_q;
		end
	end
endmodule

// ===== sv/tcp_rtt_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// TCP RTT estimator
// Per-flow timestamp RTT estimator with history variance and smoothed RTT.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result beat. A record item, an
// echo without a timestamp option or an echo whose RTT is rejected goes
// straight to the result. An accepted sample is written into the history,
// which is then walked twice through the single read port of its RAM (a read
// and an add per entry for the sum; a read, a multiply and an accumulate per
// entry for the squared deviations), and one shared divider forms the mean,
// the variance and, unless the smoothed RTT restarts from the sample, the
// smoothed RTT in turn. A result that has not been taken holds the next result
// back, but not the next item.
module tcp_rtt_estimator_unit #(
	parameter int HISTORY_DEPTH = tre_pkg::HISTORY_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	tre_item_if.sink     item,
	tre_result_if.source result,
	tre_cfg_if.sink      cfg
);
	import tre_pkg::*;

	tre_cmd_t    cmd;
	tre_status_t status;

	assign cfg.ready = 1'b1;

	tre_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_ready  (item.ready),
		.result_valid(result.valid),
		.result_ready(result.ready),
		.status      (status),
		.cmd         (cmd)
	);

	tre_dp #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.operation      (item.operation),
		.sent_tsval     (item.sent_tsval),
		.echo_tsecr     (item.echo_tsecr),
		.now_us         (item.now_us),
		.option_present (item.option_present),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.rtt_us         (result.rtt_us),
		.sample_accepted(result.sample_accepted),
		.timestamps_on  (result.timestamps_on),
		.smoothed_rtt   (result.smoothed_rtt),
		.lowest_rtt     (result.lowest_rtt),
		.highest_rtt    (result.highest_rtt),
		.rtt_variance   (result.rtt_variance),
		.sample_total   (result.sample_total)
	);

	// The minimum never exceeds the maximum of the accepted samples.
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.lowest_rtt <= result.highest_rtt))
		else $error("lowest RTT above highest RTT");

	// An applied sample is always within the accepted range.
	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.sample_accepted) |->
		(result.rtt_us != '0 && result.rtt_us < RTT_LIMIT))
		else $error("applied sample out of range");

	// Items are taken one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("item taken while another is in work");
endmodule

// ===== tb/tre_tb_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTT estimator scoreboard
// Predicts each result beat from the accepted items and checks the DUT output.
// ----------------------------------------------------------------------------
typedef struct {
	logic [31:0] rtt_us;
	logic        sample_accepted;
	logic        timestamps_on;
	logic [31:0] smoothed_rtt;
	logic [23:0] lowest_rtt;
	logic [23:0] highest_rtt;
	logic [31:0] rtt_variance;
	logic [31:0] sample_total;
} rtt_result_t;

class rtt_scoreboard;
	rtt_result_t pending[$];
	int          errors;

	bit [9:0]  weight;
	bit [31:0] restart_val;
	bit [31:0] rec_tsval, last_send_time;
	bit [31:0] history[16];
	bit [3:0]  wr_pos;
	bit [4:0]  fill;
	bit [31:0] rtt_min, rtt_max, variance, srtt, count;
	bit        ts_on;

	function void clear();
		weight = tre_pkg::WEIGHT_RESET;
		restart_val = 0;
		rec_tsval = 0;
		last_send_time = 0;
		foreach (history[i]) history[i] = 0;
		wr_pos = 0;
		fill = 0;
		rtt_min = 0;
		rtt_max = 0;
		variance = 0;
		srtt = 0;
		count = 0;
		ts_on = 0;
		errors = 0;
	endfunction

	function void write_reg(bit idx, bit [31:0] data);
		if (idx == tre_pkg::REG_SMOOTHING_WEIGHT)
			weight = data[9:0];
		else
			restart_val = data;
	endfunction

	function void take_sample(bit [31:0] rtt);
		bit [31:0] sum, avg, acc, d;
		sum = 0;
		acc = 0;
		history[wr_pos] = rtt;
		wr_pos = wr_pos + 1;
		if (fill < 16)
			fill = fill + 1;
		if (rtt < rtt_min || rtt_min == 0)
			rtt_min = rtt;
		if (rtt > rtt_max)
			rtt_max = rtt;
		for (int i = 0; i < fill; i++)
			sum = sum + history[i];
		avg = sum / fill;
		for (int i = 0; i < fill; i++) begin
			d = history[i] - avg;
			acc = acc + d * d;
		end
		variance = acc / fill;
		if (srtt == 0 || srtt == restart_val)
			srtt = rtt;
		else
			srtt = (srtt * {22'd0, weight} + rtt * (32'd1000 - {22'd0, weight})) / 32'd1000;
		count = count + 1;
	endfunction

	function void note_item(bit op, bit [31:0] tsval, bit [31:0] tsecr, bit [31:0] now,
			bit present);
		rtt_result_t r;
		bit [31:0] rtt;
		rtt = 0;
		r.sample_accepted = 0;
		if (op == 0) begin
			rec_tsval = tsval;
			last_send_time = now;
		end else if (!present) begin
			ts_on = 0;
		end else begin
			ts_on = 1;
			if (tsecr != 0 && rec_tsval != 0) begin
				if (tsecr == rec_tsval)
					rtt = now - last_send_time;
				else if (tsecr < now && (now - tsecr) < tre_pkg::RTT_LIMIT)
					rtt = now - tsecr;
			end
			if (rtt > 0 && rtt < tre_pkg::RTT_LIMIT) begin
				take_sample(rtt);
				r.sample_accepted = 1;
			end
		end
		r.rtt_us = rtt;
		r.timestamps_on = ts_on;
		r.smoothed_rtt = srtt;
		r.lowest_rtt = rtt_min[23:0];
		r.highest_rtt = rtt_max[23:0];
		r.rtt_variance = variance;
		r.sample_total = count;
		pending.push_back(r);
	endfunction

	function void check_result(rtt_result_t got);
		rtt_result_t e;
		if (pending.size() == 0) begin
			$error("unexpected result beat");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.rtt_us !== e.rtt_us) begin
			$error("rtt_us exp %0d got %0d", e.rtt_us, got.rtt_us); errors++;
		end
		if (got.sample_accepted !== e.sample_accepted) begin
			$error("sample_accepted exp %0d got %0d", e.sample_accepted, got.sample_accepted);
			errors++;
		end
		if (got.timestamps_on !== e.timestamps_on) begin
			$error("timestamps_on exp %0d got %0d", e.timestamps_on, got.timestamps_on);
			errors++;
		end
		if (got.smoothed_rtt !== e.smoothed_rtt) begin
			$error("smoothed_rtt exp %0d got %0d", e.smoothed_rtt, got.smoothed_rtt); errors++;
		end
		if (got.lowest_rtt !== e.lowest_rtt) begin
			$error("lowest_rtt exp %0d got %0d", e.lowest_rtt, got.lowest_rtt); errors++;
		end
		if (got.highest_rtt !== e.highest_rtt) begin
			$error("highest_rtt exp %0d got %0d", e.highest_rtt, got.highest_rtt); errors++;
		end
		if (got.rtt_variance !== e.rtt_variance) begin
			$error("rtt_variance exp %0d got %0d", e.rtt_variance, got.rtt_variance); errors++;
		end
		if (got.sample_total !== e.sample_total) begin
			$error("sample_total exp %0d got %0d", e.sample_total, got.sample_total); errors++;
		end
	endfunction
endclass

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTT estimator testbench
// Directed and random record/echo items with random gaps on both channels,
// register changes between phases, and every result beat checked in order.
// ----------------------------------------------------------------------------
module tb;
	import tre_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	tre_item_if   item ();
	tre_result_if result ();
	tre_cfg_if    cfg ();

	rtt_scoreboard board;
	int            idle_cycles;
	bit            stim_done;
	bit [31:0]     clock_us;
	bit [31:0]     tsval_seq;

	tcp_rtt_estimator_unit dut (
		.clk(clk), .arst_n(arst_n), .item(item.sink), .result(result.source), .cfg(cfg.sink)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 2) == 0)
			return 0;
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(20, 150);
		return $urandom_range(1, 4);
	endfunction

	task automatic send_item(bit op, bit [31:0] tsval, bit [31:0] tsecr, bit [31:0] now,
			bit present);
		int g;
		g = gap_len();
		repeat (g) @(negedge clk);
		item.valid = 1;
		item.operation = op;
		item.sent_tsval = tsval;
		item.echo_tsecr = tsecr;
		item.now_us = now;
		item.option_present = present;
		do @(posedge clk); while (!item.ready);
		board.note_item(op, tsval, tsecr, now, present);
		@(negedge clk);
		item.valid = 0;
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(bit idx, bit [31:0] data);
		drain();
		cfg.valid = 1;
		cfg.index = idx;
		cfg.data = data;
		do @(posedge clk); while (!cfg.ready);
		board.write_reg(idx, data);
		@(negedge clk);
		cfg.valid = 0;
	endtask

	// Record then echo the same TSval so that the exact-match path is taken.
	task automatic exchange(bit [31:0] rtt);
		tsval_seq = tsval_seq + $urandom_range(1, 1000);
		if (tsval_seq == 0)
			tsval_seq = 1;
		send_item(0, tsval_seq, $urandom, clock_us, 1'($urandom));
		clock_us = clock_us + rtt;
		send_item(1, $urandom, tsval_seq, clock_us, 1);
	endtask

	task automatic random_item();
		int kind;
		bit [31:0] r;
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			r = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9999999)
				: $urandom_range(1, 5000);
			exchange(r);
		end else if (kind == 6) begin
			clock_us = clock_us + $urandom_range(0, 2000);
			send_item(1, $urandom, clock_us - $urandom_range(0, 20000), clock_us, 1);
		end else if (kind == 7) begin
			send_item(1, $urandom, $urandom, $urandom, 1'($urandom));
		end else if (kind == 8) begin
			send_item(1, $urandom, $urandom, clock_us, 0);
		end else begin
			send_item(0, $urandom, $urandom, $urandom, 1'($urandom));
		end
	endtask

	// Result side: random back-pressure, checks on each beat.
	initial begin
		int g;
		rtt_result_t got;
		result.ready = 0;
		forever begin
			@(negedge clk);
			g = gap_len();
			if (g != 0) begin
				result.ready = 0;
				repeat (g - 1) @(negedge clk);
			end else
				result.ready = 1;
			result.ready = 1;
			@(posedge clk);
			if (result.valid && result.ready) begin
				got.rtt_us = result.rtt_us;
				got.sample_accepted = result.sample_accepted;
				got.timestamps_on = result.timestamps_on;
				got.smoothed_rtt = result.smoothed_rtt;
				got.lowest_rtt = result.lowest_rtt;
				got.highest_rtt = result.highest_rtt;
				got.rtt_variance = result.rtt_variance;
				got.sample_total = result.sample_total;
				board.check_result(got);
			end
		end
	end

	// Watchdog: counts cycles without any accepted beat.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((item.valid && item.ready) || (result.valid && result.ready)
					|| (cfg.valid && cfg.ready) || stim_done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		board = new();
		board.clear();
		stim_done = 0;
		item.valid = 0;
		item.operation = 0;
		item.sent_tsval = 0;
		item.echo_tsecr = 0;
		item.now_us = 0;
		item.option_present = 0;
		cfg.valid = 0;
		cfg.index = REG_SMOOTHING_WEIGHT;
		cfg.data = 0;
		arst_n = 0;
		clock_us = 32'd1000;
		tsval_seq = 32'd100;
		repeat (6) @(negedge clk);
		arst_n = 1;

		// Directed: nothing recorded, zero TSecr, missing option, field extremes.
		send_item(1, 0, 32'd5, 32'd100, 1);
		send_item(1, 0, 32'd5, 32'd100, 0);
		send_item(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
		send_item(1, 32'hFFFF_FFFF, 0, 32'd10, 1);
		send_item(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		// Exact match with wrap-around of now, then a huge rtt that is rejected.
		send_item(1, 0, 32'hFFFF_FFFF, 32'd99, 1);
		send_item(0, 32'd7, 0, 32'd0, 0);
		send_item(1, 0, 32'd7, 32'hFFFF_FFFF, 1);
		send_item(1, 0, 32'd7, 32'd0, 1);
		send_item(1, 0, 32'd7, 32'd9999999, 1);
		send_item(1, 0, 32'd7, 32'd10000000, 1);
		// TSecr read as a time: in range, at the limit, and not yet in the past.
		send_item(1, 0, 32'd500, 32'd10000499, 1);
		send_item(1, 0, 32'd500, 32'd10000500, 1);
		send_item(1, 0, 32'd600, 32'd600, 1);
		send_item(1, 0, 32'd700, 32'd650, 1);
		// Fill the history past its depth.
		repeat (18) exchange($urandom_range(1, 300));

		write_reg(REG_SMOOTHING_WEIGHT, 32'd0);
		write_reg(REG_SRTT_RESTART_VALUE, 32'hFFFF_FFFF);
		repeat (50) random_item();
		write_reg(REG_SMOOTHING_WEIGHT, 32'd1000);
		repeat (50) random_item();
		write_reg(REG_SMOOTHING_WEIGHT, 32'd1023);
		write_reg(REG_SRTT_RESTART_VALUE, board.srtt);
		repeat (50) random_item();
		write_reg(REG_SMOOTHING_WEIGHT, 32'd1001);
		write_reg(REG_SRTT_RESTART_VALUE, 32'd0);
		repeat (50) random_item();
		for (int p = 0; p < 4; p++) begin
			write_reg(REG_SMOOTHING_WEIGHT, $urandom_range(0, 1023));
			write_reg(REG_SRTT_RESTART_VALUE, ($urandom_range(0, 1)) ? board.srtt : $urandom);
			repeat (35) random_item();
		end
		write_reg(REG_SMOOTHING_WEIGHT, tre_pkg::WEIGHT_RESET);
		repeat (35) random_item();

		drain();
		repeat (200) @(negedge clk);
		stim_done = 1;
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
